>>> hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, widths, register indexes and status codes of the fixed block
// pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   // Payload and register widths
   localparam int HANDLE_W    = 9;
   localparam int SIZE_W      = 16;
   localparam int ADDR_W      = 32;
   localparam int BYTES_W     = 24;
   localparam int COUNT_W     = 32;
   localparam int STATUS_W    = 3;
   localparam int BCOUNT_W    = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Parameter defaults
   localparam int DEF_MAX_BLOCKS = 256;
   localparam int DEF_ALIGN      = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_ADDRESS = 2'd2;

   // Register reset values
   localparam logic [SIZE_W-1:0]   RST_BLOCK_SIZE   = 16'd64;
   localparam logic [BCOUNT_W-1:0] RST_BLOCK_COUNT  = 9'd256;
   localparam logic [ADDR_W-1:0]   RST_BASE_ADDRESS = 32'd0;

   // Request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SIZE      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NULL_FREE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE  = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic sweep;
      logic accept;
      logic commit;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic relink;
      logic sweep_last;
   } dp_sts_type;

   // One result transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] block_handle;
      logic [ADDR_W-1:0]   block_address;
      logic [BYTES_W-1:0]  bytes_in_use;
      logic [COUNT_W-1:0]  alloc_count;
      logic [COUNT_W-1:0]  free_count;
   } rsp_payload_type;

endpackage

>>> hw/rtl/fbpa_req_if.sv
// ----------------------------------------------------------------------------
// fbpa_req_if
// Request channel: valid/ready handshake with the allocate/free payload.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
   import fbpa_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SIZE_W-1:0]   request_size;
   logic [HANDLE_W-1:0] free_handle;

   modport source (output valid, output req_type, output request_size,
                   output free_handle, input ready);
   modport sink   (input valid, input req_type, input request_size,
                   input free_handle, output ready);
endinterface

>>> hw/rtl/fbpa_rsp_if.sv
// ----------------------------------------------------------------------------
// fbpa_rsp_if
// Response channel: valid/ready handshake with the allocator result payload.
// ----------------------------------------------------------------------------
interface fbpa_rsp_if;
   import fbpa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] block_handle;
   logic [ADDR_W-1:0]   block_address;
   logic [BYTES_W-1:0]  bytes_in_use;
   logic [COUNT_W-1:0]  alloc_count;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, output status, output block_handle,
                   output block_address, output bytes_in_use, output alloc_count,
                   output free_count, input ready);
   modport sink   (input valid, input status, input block_handle,
                   input block_address, input bytes_in_use, input alloc_count,
                   input free_count, output ready);
endinterface

>>> hw/rtl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Controller: sequences link-memory initialization, transaction accept and
// commit, and owns the response valid flag.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fbpa_pkg::dp_cmd_type   cmd,
   input  fbpa_pkg::dp_sts_type   sts
);
   import fbpa_pkg::*;

   localparam logic [1:0] S_SWEEP = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_BUSY  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Decode commands from the current state
   always_comb begin
      cmd.sweep  = (state_ff == S_SWEEP);
      cmd.accept = (state_ff == S_IDLE) && !sts.relink && req_valid;
      cmd.commit = (state_ff == S_BUSY) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == S_IDLE) && !sts.relink;
   assign rsp_valid = rsp_valid_ff;

   // Advance the state; a relink restarts the initialization sweep
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_SWEEP: begin
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd.accept) begin
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (cmd.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
      if (sts.relink) begin
         state_in = S_SWEEP;
      end
   end

   // Hold the response until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> hw/rtl/fbpa_dp.sv
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: configuration registers, free-list head and counters, link memory,
// size check, address arithmetic and the response register.
// ----------------------------------------------------------------------------
module fbpa_dp #(
   parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
   parameter int ALIGN      = fbpa_pkg::DEF_ALIGN
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbpa_pkg::dp_cmd_type                cmd,
   output fbpa_pkg::dp_sts_type                sts,
   input  logic                                csr_write_en,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                req_type,
   input  logic [fbpa_pkg::SIZE_W-1:0]         request_size,
   input  logic [fbpa_pkg::HANDLE_W-1:0]       free_handle,
   output fbpa_pkg::rsp_payload_type           rsp
);
   import fbpa_pkg::*;

   localparam int IW    = $clog2(MAX_BLOCKS);
   // Round-up by reciprocal multiply: t = size + ALIGN - 1, q = floor(t / ALIGN)
   localparam int TW    = SIZE_W + 1;
   localparam int AB    = $clog2(ALIGN);
   localparam int SHIFT = TW + AB;
   localparam int MW    = TW + 2;
   localparam int PW    = TW + MW;
   localparam int RW    = TW + 7;
   localparam int OW    = HANDLE_W + SIZE_W;
   localparam logic [MW-1:0] RECIP = MW'(((2 ** SHIFT) + ALIGN - 1) / ALIGN);

   // Configuration and control state
   logic [SIZE_W-1:0]   bsize_ff, bsize_in;
   logic [BCOUNT_W-1:0] bcount_ff, bcount_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [HANDLE_W-1:0] head_ff, head_in;
   logic [HANDLE_W-1:0] in_use_ff, in_use_in;
   logic [COUNT_W-1:0]  alloc_ff, alloc_in;
   logic [COUNT_W-1:0]  free_ff, free_in;
   logic [IW-1:0]       ctr_ff, ctr_in;

   // Transaction and result payload
   logic                type_ff;
   logic [HANDLE_W-1:0] fh_ff;
   logic [TW-1:0]       quot_ff, quot_in;
   logic [OW-1:0]       off_ff, off_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic [HANDLE_W-1:0] eff_n;
   logic [HANDLE_W-1:0] head_m1;
   logic [TW-1:0]       size_t;
   logic [PW-1:0]       prod;
   logic [RW-1:0]       rounded;
   logic                size_ok, head_ok, exhausted, alloc_ok;
   logic                free_null, free_bad, free_ok;
   logic [HANDLE_W-1:0] in_use_next;
   logic [OW-1:0]       bytes_wide;
   logic [HANDLE_W-1:0] init_link;
   logic                ram_we;
   logic [IW-1:0]       ram_waddr;
   logic [HANDLE_W-1:0] ram_wdata;
   logic [HANDLE_W-1:0] link_rd;

   // Effective block count: zero acts as one, clamp to the pool size
   always_comb begin
      if (bcount_ff == '0) begin
         eff_n = HANDLE_W'(1);
      end else if (32'(bcount_ff) > 32'(MAX_BLOCKS)) begin
         eff_n = HANDLE_W'(MAX_BLOCKS);
      end else begin
         eff_n = bcount_ff;
      end
   end

   assign sts.relink     = csr_write_en && (csr_index == REG_BLOCK_COUNT);
   assign sts.sweep_last = (ctr_ff == IW'(MAX_BLOCKS - 1));

   // Initial chain entry for the sweep position
   assign init_link = ((32'(ctr_ff) + 32'd1) < 32'(eff_n)) ?
                      (HANDLE_W'(ctr_ff) + HANDLE_W'(2)) : '0;

   // Accept stage: quotient of the rounded size and offset of the head block
   assign head_m1 = head_ff - HANDLE_W'(1);
   assign size_t  = TW'(request_size) + TW'(ALIGN - 1);
   assign prod    = PW'(size_t) * PW'(RECIP);
   assign quot_in = TW'(prod >> SHIFT);
   assign off_in  = OW'(head_m1) * OW'(bsize_ff);

   // Commit stage checks
   assign rounded   = RW'(quot_ff) * RW'(ALIGN);
   assign size_ok   = (rounded == RW'(bsize_ff));
   assign head_ok   = (head_ff != '0) && (32'(head_ff) <= 32'(MAX_BLOCKS));
   assign exhausted = (in_use_ff >= eff_n) || !head_ok;
   assign alloc_ok  = (type_ff == REQ_ALLOC) && size_ok && !exhausted;
   assign free_null = (fh_ff == '0);
   assign free_bad  = (fh_ff > eff_n) || (in_use_ff == '0);
   assign free_ok   = (type_ff == REQ_FREE) && !free_null && !free_bad;

   always_comb begin
      in_use_next = in_use_ff;
      if (alloc_ok) begin
         in_use_next = in_use_ff + HANDLE_W'(1);
      end else if (free_ok) begin
         in_use_next = in_use_ff - HANDLE_W'(1);
      end
   end

   assign bytes_wide = OW'(in_use_next) * OW'(bsize_ff);

   // Link memory write: sweep initialization or push of a freed handle
   assign ram_we    = cmd.sweep || (cmd.commit && free_ok);
   assign ram_waddr = cmd.sweep ? ctr_ff : IW'(fh_ff - HANDLE_W'(1));
   assign ram_wdata = cmd.sweep ? init_link : head_ff;

   fbpa_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (IW'(head_m1)),
      .rd_data (link_rd)
   );

   // Build the result of the committed transaction
   always_comb begin
      rsp_in               = rsp_ff;
      rsp_in.block_handle  = '0;
      rsp_in.block_address = '0;
      if (type_ff == REQ_ALLOC) begin
         if (!size_ok) begin
            rsp_in.status = STATUS_SIZE;
         end else if (exhausted) begin
            rsp_in.status = STATUS_EXHAUSTED;
         end else begin
            rsp_in.status        = STATUS_OK;
            rsp_in.block_handle  = head_ff;
            rsp_in.block_address = base_ff + ADDR_W'(off_ff);
         end
      end else begin
         if (free_null) begin
            rsp_in.status = STATUS_NULL_FREE;
         end else if (free_bad) begin
            rsp_in.status = STATUS_BAD_FREE;
         end else begin
            rsp_in.status = STATUS_OK;
         end
      end
      rsp_in.bytes_in_use = bytes_wide[BYTES_W-1:0];
      rsp_in.alloc_count  = alloc_ok ? (alloc_ff + COUNT_W'(1)) : alloc_ff;
      rsp_in.free_count   = free_ok ? (free_ff + COUNT_W'(1)) : free_ff;
   end

   // Next control state: commit updates, then register writes
   always_comb begin
      bsize_in  = bsize_ff;
      bcount_in = bcount_ff;
      base_in   = base_ff;
      head_in   = head_ff;
      in_use_in = in_use_ff;
      alloc_in  = alloc_ff;
      free_in   = free_ff;
      ctr_in    = ctr_ff;

      if (cmd.sweep) begin
         ctr_in = ctr_ff + IW'(1);
      end

      if (cmd.commit) begin
         in_use_in = in_use_next;
         alloc_in  = rsp_in.alloc_count;
         free_in   = rsp_in.free_count;
         if (alloc_ok) begin
            head_in = link_rd;
         end else if (free_ok) begin
            head_in = fh_ff;
         end
      end

      if (csr_write_en) begin
         unique case (csr_index)
            REG_BLOCK_SIZE: begin
               bsize_in = csr_write_data[SIZE_W-1:0];
            end
            REG_BLOCK_COUNT: begin
               bcount_in = csr_write_data[BCOUNT_W-1:0];
               head_in   = HANDLE_W'(1);
               in_use_in = '0;
               ctr_in    = '0;
            end
            REG_BASE_ADDRESS: begin
               base_in = csr_write_data[ADDR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff  <= RST_BLOCK_SIZE;
         bcount_ff <= RST_BLOCK_COUNT;
         base_ff   <= RST_BASE_ADDRESS;
         head_ff   <= HANDLE_W'(1);
         in_use_ff <= '0;
         alloc_ff  <= '0;
         free_ff   <= '0;
         ctr_ff    <= '0;
      end else begin
         bsize_ff  <= bsize_in;
         bcount_ff <= bcount_in;
         base_ff   <= base_in;
         head_ff   <= head_in;
         in_use_ff <= in_use_in;
         alloc_ff  <= alloc_in;
         free_ff   <= free_in;
         ctr_ff    <= ctr_in;
      end
   end

   // Capture the transaction on accept, the result on commit
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff <= req_type;
         fh_ff   <= free_handle;
         quot_ff <= quot_in;
         off_ff  <= off_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;
endmodule

>>> hw/rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a linked free list in a link memory; allocates
// by popping the list head and frees by pushing the handle back.
// ----------------------------------------------------------------------------
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    req_type, request_size, free_handle
//   rsp_chan  out        valid / ready    status, block_handle, block_address,
//                                         bytes_in_use, alloc_count, free_count
//   csr_*     in         csr_write_en     csr_index, csr_write_data
//
// A transaction is accepted, launching the link-memory read at the current
// head, then committed with the read data once the response slot is free.
// After reset and after every block_count write the link memory is rewritten
// one entry per cycle, all MAX_BLOCKS entries, with req_chan.ready low.
// The result sits in an output register; a new transaction is accepted while
// it waits, and only the commit stalls until the response slot frees up.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
   parameter int ALIGN      = fbpa_pkg::DEF_ALIGN
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]  csr_write_data,
   fbpa_req_if.sink                         req_chan,
   fbpa_rsp_if.source                       rsp_chan
);
   import fbpa_pkg::*;

   dp_cmd_type      cmd;
   dp_sts_type      sts;
   rsp_payload_type rsp;
   logic            req_ready;
   logic            rsp_valid;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fbpa_dp #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ALIGN      (ALIGN)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_type       (req_chan.req_type),
      .request_size   (req_chan.request_size),
      .free_handle    (req_chan.free_handle),
      .rsp            (rsp)
   );

   // Drive the channels
   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.status        = rsp.status;
   assign rsp_chan.block_handle  = rsp.block_handle;
   assign rsp_chan.block_address = rsp.block_address;
   assign rsp_chan.bytes_in_use  = rsp.bytes_in_use;
   assign rsp_chan.alloc_count   = rsp.alloc_count;
   assign rsp_chan.free_count    = rsp.free_count;

   // No transaction enters while the link memory is being initialized
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !req_chan.ready)
      else $error("transaction accepted during link memory sweep");

   // A commit always presents a response in the next cycle
   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_chan.valid)
      else $error("commit without response");

   // An accepted transaction blocks the next one until it commits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second transaction accepted while one is in flight");

   // A block_count write restarts the initialization sweep
   a_relink_sweeps: assert property (@(posedge clock) disable iff (reset)
      sts.relink |=> cmd.sweep)
      else $error("block_count write did not start a sweep");
endmodule
